// ===== design/awtl_pkg.sv =====
// ----------------------------------------------------------------------------
// awtl_pkg
// Shared types, sizes and helpers for the address window target lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package awtl_pkg;

    // number of windows held in the table (1 to 32)
    localparam int WINDOW_COUNT = 32;
    localparam int IDX_W        = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;

    // fixed field widths
    localparam int ADDR_W       = 64;
    localparam int SIZE_W       = 6;
    localparam int TGT_W        = 8;
    localparam int ENTRY_IDX_W  = 5;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [TGT_W-1:0]  t_tgt;

    // one stored window, less its enable bit (that lives in flops)
    typedef struct packed {
        t_addr base;
        t_size size;
        t_tgt  target;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam t_idx LAST_IDX = t_idx'(WINDOW_COUNT - 1);

    // offsets below 2^(code+1) lie inside the window: bits [code:0] set
    function automatic t_addr f_span_mask(input t_size code);
        t_addr ones;
        ones = '1;
        return ones >> (t_size'(ADDR_W - 1) - code);
    endfunction

endpackage

// ===== design/awtl_ram.sv =====
// ----------------------------------------------------------------------------
// awtl_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awtl_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/awtl_match.sv =====
// ----------------------------------------------------------------------------
// awtl_match
// Window containment test: base <= address < base + 2^(size+1), 65-bit bound.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awtl_match (
    input  awtl_pkg::t_entry i_entry,
    input  awtl_pkg::t_addr  i_address,
    output logic             o_hold
);

    logic [awtl_pkg::ADDR_W:0] w_diff;
    awtl_pkg::t_addr           w_mask;

    // offset from base; top bit is the borrow (address below base)
    assign w_diff = {1'b0, i_address} - {1'b0, i_entry.base};
    assign w_mask = awtl_pkg::f_span_mask(i_entry.size);

    // no wrap possible: offset is at most 2^64-1, so the largest code always holds
    assign o_hold = !w_diff[awtl_pkg::ADDR_W]
                    && ((w_diff[awtl_pkg::ADDR_W-1:0] & ~w_mask) == '0);

endmodule

// ===== design/address_window_target_lookup_top.sv =====
// ----------------------------------------------------------------------------
// address_window_target_lookup_top
// Table of address windows, each mapping a base/size range to a target id.
//
// Usage: a beat is taken on start while busy is low. Mode 1 writes one
// window entry (base, size code, enable, target); it completes in the cycle
// it is taken, gives no result and busy stays low. Mode 0 looks up an
// address: entries are read from the window RAM one per cycle from entry 0
// upward, and the first enabled window holding the address ends the scan.
// The result (hit, target) is shown for one cycle with o_strobe, registered
// once the matching entry, or the last entry on a miss, is checked; busy
// is high from the cycle after the beat until the strobe cycle, in which
// the next beat may already be taken. The scan rate is set by the
// single read port of the window RAM. Reset clears every enable bit (so
// all windows read as disabled) and the scan control; base, size and
// target of an unwritten entry are never used. The receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module address_window_target_lookup_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_mode,
    input  logic [awtl_pkg::ENTRY_IDX_W-1:0] i_entry_index,
    input  logic [awtl_pkg::ADDR_W-1:0]      i_window_base,
    input  logic [awtl_pkg::SIZE_W-1:0]      i_size_code,
    input  logic                              i_window_enable,
    input  logic [awtl_pkg::TGT_W-1:0]       i_window_target,
    input  logic [awtl_pkg::ADDR_W-1:0]      i_lookup_address,
    output logic                              o_strobe,
    output logic                              o_hit,
    output logic [awtl_pkg::TGT_W-1:0]       o_target
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state             r_state, n_state;
    awtl_pkg::t_idx     r_chk_idx, n_chk_idx;
    awtl_pkg::t_addr    r_addr;
    logic               r_strobe, n_strobe;
    logic               r_hit, n_hit;
    awtl_pkg::t_tgt     r_target, n_target;
    logic               r_en [awtl_pkg::WINDOW_COUNT];

    logic               w_accept;
    logic               w_wr_en;
    awtl_pkg::t_idx     w_wr_idx;
    awtl_pkg::t_entry   w_wr_entry;
    logic               w_rd_en;
    awtl_pkg::t_idx     w_rd_idx;
    awtl_pkg::t_entry   w_rd_entry;
    logic               w_hold;
    logic               w_match;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // writes beyond the table are dropped
    assign w_wr_en  = w_accept && i_mode
                      && (32'(i_entry_index) < 32'(awtl_pkg::WINDOW_COUNT));
    assign w_wr_idx = awtl_pkg::t_idx'(i_entry_index);

    assign w_wr_entry.base   = i_window_base;
    assign w_wr_entry.size   = i_size_code;
    assign w_wr_entry.target = i_window_target;

    awtl_ram #(
        .WIDTH (awtl_pkg::ENTRY_W),
        .DEPTH (awtl_pkg::WINDOW_COUNT)
    ) u_win_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_idx),
        .i_wr_data (w_wr_entry),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_idx),
        .o_rd_data (w_rd_entry)
    );

    awtl_match u_match (
        .i_entry   (w_rd_entry),
        .i_address (r_addr),
        .o_hold    (w_hold)
    );

    // RAM output holds entry r_chk_idx during a scan cycle
    assign w_match = r_en[r_chk_idx] && w_hold;

    // enable bits in flops so reset disables every window at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < awtl_pkg::WINDOW_COUNT; i++) begin
                r_en[i] <= 1'b0;
            end
        end else if (w_wr_en) begin
            r_en[w_wr_idx] <= i_window_enable;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_chk_idx = r_chk_idx;
        n_strobe  = 1'b0;
        n_hit     = r_hit;
        n_target  = r_target;
        w_rd_en   = 1'b0;
        w_rd_idx  = r_chk_idx + awtl_pkg::t_idx'(1);
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && !i_mode) begin
                    n_state   = S_SCAN;
                    n_chk_idx = '0;
                    w_rd_en   = 1'b1;
                    w_rd_idx  = '0;
                end
            end
            S_SCAN: begin
                if (w_match || (r_chk_idx == awtl_pkg::LAST_IDX)) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_hit    = w_match;
                    n_target = w_match ? w_rd_entry.target : '0;
                end else begin
                    // fetch the next entry while this one is checked
                    n_chk_idx = r_chk_idx + awtl_pkg::t_idx'(1);
                    w_rd_en   = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // scan payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_chk_idx <= n_chk_idx;
        r_hit     <= n_hit;
        r_target  <= n_target;
        if (w_accept && !i_mode) begin
            r_addr <= i_lookup_address;
        end
    end

    assign o_strobe = r_strobe;
    assign o_hit    = r_hit;
    assign o_target = r_target;

`ifndef SYNTHESIS
    a_strobe_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_SCAN))
        else $error("result strobe without a preceding scan");

    a_miss_zero_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_hit) |-> (o_target == '0))
        else $error("miss reported with non-zero target");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_chk_idx <= awtl_pkg::LAST_IDX))
        else $error("scan index beyond the table");

    a_strobe_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("busy still high in the result cycle");

    a_write_keeps_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_mode) |=> !busy)
        else $error("write beat started a scan");
`endif

endmodule

// ===== sim/address_window_target_lookup_top_tb.sv =====
// ----------------------------------------------------------------------------
// address_window_target_lookup_top_tb
// Self-checking bench for the address window table. Writes fill window
// entries and lookups are scored against a local copy of the table. It covers
// window edges, overlap priority, disabled entries, full-space windows,
// windows that run past the top, random traffic, idle gaps and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module address_window_target_lookup_top_tb;

    // beat kinds on i_mode
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;

    // cycles allowed after the last result: a miss scans the whole table
    localparam int TAIL_CYCLES  = awtl_pkg::WINDOW_COUNT + 8;

    typedef struct packed {
        logic             hit;
        awtl_pkg::t_tgt   target;
    } t_lookup_result;

    // ------------------------------------------------------------------------
    // Clock, DUT pins
    // ------------------------------------------------------------------------
    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             start;
    logic                             busy;
    logic                             i_mode;
    logic [awtl_pkg::ENTRY_IDX_W-1:0] i_entry_index;
    awtl_pkg::t_addr                  i_window_base;
    awtl_pkg::t_size                  i_size_code;
    logic                             i_window_enable;
    awtl_pkg::t_tgt                   i_window_target;
    awtl_pkg::t_addr                  i_lookup_address;
    logic                             o_strobe;
    logic                             o_hit;
    awtl_pkg::t_tgt                   o_target;

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    address_window_target_lookup_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_entry_index    (i_entry_index),
        .i_window_base    (i_window_base),
        .i_size_code      (i_size_code),
        .i_window_enable  (i_window_enable),
        .i_window_target  (i_window_target),
        .i_lookup_address (i_lookup_address),
        .o_strobe         (o_strobe),
        .o_hit            (o_hit),
        .o_target         (o_target)
    );

    // ------------------------------------------------------------------------
    // Local copy of the window table and the queue of expected lookups
    // ------------------------------------------------------------------------
    awtl_pkg::t_addr win_base [awtl_pkg::WINDOW_COUNT];
    awtl_pkg::t_size win_size [awtl_pkg::WINDOW_COUNT];
    logic            win_on   [awtl_pkg::WINDOW_COUNT];
    awtl_pkg::t_tgt  win_tgt  [awtl_pkg::WINDOW_COUNT];
    t_lookup_result  pending_lookups[$];

    int  error_count  = 0;
    int  writes_sent  = 0;
    int  lookups_sent = 0;
    int  hits_seen    = 0;
    int  misses_seen  = 0;
    bit  calm         = 1'b0;   // no idle cycles while set

    function automatic awtl_pkg::t_addr rand64();
        return {$urandom, $urandom};
    endfunction

    // byte span of a size code, taken at 65 bits so code 63 gives 2^64
    function automatic logic [awtl_pkg::ADDR_W:0] span_of(input awtl_pkg::t_size code);
        return {{awtl_pkg::ADDR_W{1'b0}}, 1'b1} << (int'(code) + 1);
    endfunction

    // base <= addr < base + span, upper bound at 65 bits so nothing wraps
    function automatic logic window_covers(input awtl_pkg::t_addr base,
                                           input awtl_pkg::t_size code,
                                           input awtl_pkg::t_addr addr);
        logic [awtl_pkg::ADDR_W:0] upper;
        upper = {1'b0, base} + span_of(code);
        return (addr >= base) && ({1'b0, addr} < upper);
    endfunction

    // lowest-numbered enabled window wins; no match gives hit 0, target 0
    function automatic t_lookup_result resolve_target(input awtl_pkg::t_addr addr);
        t_lookup_result res;
        res = '0;
        for (int i = 0; i < awtl_pkg::WINDOW_COUNT; i++) begin
            if (win_on[i] && window_covers(win_base[i], win_size[i], addr)) begin
                res.hit    = 1'b1;
                res.target = win_tgt[i];
                return res;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Beat driver. Called just after a rising edge. Holds start high (with
    // random drops) until a beat is taken, then updates the local table or
    // queues the expected lookup result, then idles at random.
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic mode,
                             input logic [awtl_pkg::ENTRY_IDX_W-1:0] idx,
                             input awtl_pkg::t_addr base, input awtl_pkg::t_size code,
                             input logic en, input awtl_pkg::t_tgt tgt,
                             input awtl_pkg::t_addr addr);
        start            <= 1'b1;
        i_mode           <= mode;
        i_entry_index    <= idx;
        i_window_base    <= base;
        i_size_code      <= code;
        i_window_enable  <= en;
        i_window_target  <= tgt;
        i_lookup_address <= addr;
        forever begin
            @(posedge i_clk);
            if (start && !busy) break;
            // drops while waiting land gaps on every phase of the scan
            start <= calm || ($urandom_range(99) >= 31);
        end
        if (mode == MODE_WRITE) begin
            if (int'(idx) < awtl_pkg::WINDOW_COUNT) begin
                win_base[idx] = base;
                win_size[idx] = code;
                win_on[idx]   = en;
                win_tgt[idx]  = tgt;
            end
            writes_sent++;
        end else begin
            pending_lookups.push_back(resolve_target(addr));
            lookups_sent++;
        end
        while (!calm && $urandom_range(99) < 31) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // unused fields carry random noise on both kinds of beat
    task automatic write_window(input logic [awtl_pkg::ENTRY_IDX_W-1:0] idx,
                                input awtl_pkg::t_addr base, input awtl_pkg::t_size code,
                                input logic en, input awtl_pkg::t_tgt tgt);
        send_beat(MODE_WRITE, idx, base, code, en, tgt, rand64());
    endtask

    task automatic look_up(input awtl_pkg::t_addr addr);
        send_beat(MODE_LOOKUP, awtl_pkg::ENTRY_IDX_W'($urandom), rand64(),
                  awtl_pkg::t_size'($urandom), 1'($urandom),
                  awtl_pkg::t_tgt'($urandom), addr);
    endtask

    // always moves on by at least one edge
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (pending_lookups.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every strobe beat is matched against the oldest lookup
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_lookup_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_lookups.size() == 0) begin
                error_count++;
                $display("%0t: result beat with none expected: hit %b target %02h",
                         $realtime, o_hit, o_target);
            end else begin
                want = pending_lookups.pop_front();
                if (o_hit !== want.hit) begin
                    error_count++;
                    $display("%0t: hit mismatch: expected %b actual %b",
                             $realtime, want.hit, o_hit);
                end
                if (o_target !== want.target) begin
                    error_count++;
                    $display("%0t: target mismatch: expected %02h actual %02h",
                             $realtime, want.target, o_target);
                end
                if (want.hit) hits_seen++;
                else          misses_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // all enables clear after reset: nothing may hit
    task automatic test_empty_table();
        look_up('0);
        look_up('1);
        look_up(64'h8000_0000_0000_0000);
    endtask

    // smallest window, window past the top, full-space window, target id 0
    task automatic test_window_edges();
        write_window(5'd0, '0, 6'd0, 1'b1, 8'h00);      // bytes 0..1, target 0
        look_up(64'd0);
        look_up(64'd1);
        look_up(64'd2);
        // 2 KiB window from 16 bytes below the top: upper bound carries out
        write_window(5'd31, 64'hFFFF_FFFF_FFFF_FFF0, 6'd10, 1'b1, 8'hFF);
        look_up('1);
        look_up(64'hFFFF_FFFF_FFFF_FFEF);
        // largest size code covers everything from its base upward
        write_window(5'd5, 64'h0000_0000_0000_1000, 6'd63, 1'b1, 8'h5A);
        look_up(64'h0000_0000_0000_0FFF);
        look_up(64'h0000_0000_0000_1000);
        look_up('1);
    endtask

    // lower index wins on overlap; disabled entries are skipped
    task automatic test_overlap_priority();
        write_window(5'd3, 64'h0000_0000_0000_1000, 6'd20, 1'b0, 8'h33);
        look_up(64'h0000_0000_0000_1000);
        write_window(5'd3, 64'h0000_0000_0000_1000, 6'd20, 1'b1, 8'h33);
        look_up(64'h0000_0000_0000_1000);
        look_up(64'h0000_0000_0020_0FFF);   // last byte of entry 3
        look_up(64'h0000_0000_0020_1000);   // just past it, entry 5 still holds
        write_window(5'd1, '0, 6'd63, 1'b1, 8'hC3);     // whole space
        look_up(64'd7);
        write_window(5'd0, '0, 6'd0, 1'b0, 8'h00);      // disable entry 0
        look_up(64'd0);
    endtask

    // sender holds off until the table has answered everything, then resumes
    task automatic test_drain_pause();
        look_up(rand64());
        look_up(64'h0000_0000_0000_1000);
        start <= 1'b0;
        wait_drained();
        look_up(64'd1);
        write_window(5'd1, '0, 6'd0, 1'b0, 8'h00);
        look_up(64'd1);
    endtask

    // mostly lookups aimed inside or at the edges of written windows
    task automatic test_random_mix(input int n_items);
        logic [awtl_pkg::ENTRY_IDX_W-1:0] idx;
        awtl_pkg::t_addr                  base;
        awtl_pkg::t_addr                  addr;
        awtl_pkg::t_addr                  offset_mask;
        awtl_pkg::t_size                  code;
        int                               pick;
        int                               j;
        for (int n = 0; n < n_items; n++) begin
            calm = (n >= n_items / 3) && (n < n_items / 3 + 120);
            pick = $urandom_range(99);
            j    = $urandom_range(awtl_pkg::WINDOW_COUNT - 1);
            if (pick < 35) begin
                idx  = awtl_pkg::ENTRY_IDX_W'($urandom);
                code = ($urandom_range(99) < 70) ? awtl_pkg::t_size'($urandom_range(15))
                                                 : awtl_pkg::t_size'($urandom_range(63));
                case ($urandom_range(3))
                    0:       base = win_base[j];                        // overlap
                    1:       base = '1 - awtl_pkg::t_addr'($urandom_range(4095));
                    default: base = rand64();
                endcase
                write_window(idx, base, code, $urandom_range(99) < 85,
                             awtl_pkg::t_tgt'($urandom));
            end else begin
                // offsets inside window j: span less one, cut to 64 bits
                offset_mask = awtl_pkg::t_addr'(span_of(win_size[j]) - 1);
                case ($urandom_range(9))
                    0:       addr = win_base[j] - awtl_pkg::t_addr'(1);
                    1:       addr = win_base[j] + offset_mask + awtl_pkg::t_addr'(1);
                    2:       addr = win_base[j] + offset_mask;
                    3, 4:    addr = rand64();
                    default: addr = win_base[j] + (rand64() & offset_mask);
                endcase
                look_up(addr);
            end
            if (n % 150 == 149) begin
                start <= 1'b0;
                wait_drained();
            end
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_mode           <= MODE_LOOKUP;
        i_entry_index    <= '0;
        i_window_base    <= '0;
        i_size_code      <= '0;
        i_window_enable  <= 1'b0;
        i_window_target  <= '0;
        i_lookup_address <= '0;
        for (int i = 0; i < awtl_pkg::WINDOW_COUNT; i++) begin
            win_base[i] = '0;
            win_size[i] = '0;
            win_on[i]   = 1'b0;
            win_tgt[i]  = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_window_edges();
        test_overlap_priority();
        test_drain_pause();
        test_random_mix(600);

        start <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d window writes and %0d lookups (%0d hits, %0d misses),",
                 writes_sent, lookups_sent, hits_seen, misses_seen);
        $display("with overlaps, disabled and full-space windows and idle gaps.");
        if (error_count == 0) begin
            $display("[address_window_target_lookup_top] OK");
        end else begin
            $display("[address_window_target_lookup_top] ERROR");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("[address_window_target_lookup_top] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/awtl_pkg.sv
design/awtl_ram.sv
design/awtl_match.sv
design/address_window_target_lookup_top.sv
sim/address_window_target_lookup_top_tb.sv
